// ===== rtl/ttps_pkg.sv =====
package ttps_pkg;

	// Default table size: 2^12 slots
	localparam int TTPS_INDEX_BITS = 12;

	// Operation codes
	localparam logic [1:0] FUNC_PROBE    = 2'd0;
	localparam logic [1:0] FUNC_STORE    = 2'd1;
	localparam logic [1:0] FUNC_NEW_ITER = 2'd2;

	// Entry kinds
	localparam logic [1:0] KIND_EXACT = 2'd0;
	localparam logic [1:0] KIND_LOWER = 2'd1;
	localparam logic [1:0] KIND_UPPER = 2'd2;

	// Input beat
	typedef struct packed {
		logic [1:0]         func;
		logic [63:0]        key;
		logic signed [31:0] alpha;
		logic signed [31:0] beta;
		logic [6:0]         depth;
		logic signed [31:0] score;
		logic [1:0]         bound_kind;
		logic [15:0]        move_code;
	} item_t;

	// Result beat
	typedef struct packed {
		logic               hit;
		logic signed [31:0] found_score;
		logic [6:0]         found_depth;
		logic [1:0]         found_kind;
		logic [15:0]        found_move;
		logic               replaced;
	} result_t;

	// One table slot as held in the memory
	typedef struct packed {
		logic               valid;
		logic [63:0]        key;
		logic signed [31:0] score;
		logic [6:0]         depth;
		logic [1:0]         kind;
		logic [15:0]        move;
		logic [15:0]        age;
	} slot_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clr_en;
		logic accept;
		logic eval;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
	} status_t;

endpackage

// ===== rtl/ttps_ctrl.sv =====
module ttps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ttps_pkg::status_t status,
	output ttps_pkg::cmd_t    cmd,
	output logic              busy
);
	import ttps_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EVAL  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Sequence: clearing pass, then accept / evaluate per beat
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_nxt = ST_EVAL;
			end
			ST_EVAL: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Drive commands from the current state
	always_comb begin
		cmd.clr_en = (state_q == ST_CLEAR);
		cmd.accept = (state_q == ST_IDLE) && start;
		cmd.eval   = (state_q == ST_EVAL);
		busy       = (state_q != ST_IDLE);
	end

endmodule

// ===== rtl/ttps_dp.sv =====
module ttps_dp #(
	parameter int INDEX_BITS = ttps_pkg::TTPS_INDEX_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ttps_pkg::cmd_t    cmd,
	input  ttps_pkg::item_t   item,
	output ttps_pkg::status_t status,
	output ttps_pkg::result_t result,
	output logic              done
);
	import ttps_pkg::*;

	localparam int SLOTS = 1 << INDEX_BITS;

	slot_t                  mem [SLOTS];
	slot_t                  rd_q;
	item_t                  item_q;
	logic [INDEX_BITS-1:0]  clr_q;
	logic [15:0]            age_q;
	result_t                res_q;
	logic                   done_q;

	logic [INDEX_BITS-1:0]  item_idx;
	logic                   same_key;
	logic                   deeper;
	logic                   same_depth;
	logic                   usable;
	logic                   probe_hit;
	logic                   store_write;
	logic                   wr_en;
	logic [INDEX_BITS-1:0]  wr_addr;
	slot_t                  wr_word;
	result_t                res_nxt;

	assign item_idx = item_q.key[INDEX_BITS-1:0];

	// Sweep the table empty after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_en) begin
			clr_q <= clr_q + INDEX_BITS'(1);
		end
	end

	assign status.clr_last = &clr_q;

	// Latch the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.accept) item_q <= item;
	end

	// Evaluate the slot against the held beat
	always_comb begin
		same_key   = (rd_q.key == item_q.key);
		deeper     = (item_q.depth > rd_q.depth);
		same_depth = (item_q.depth == rd_q.depth);
		usable     = (rd_q.kind == KIND_EXACT) ||
		             ((rd_q.kind == KIND_LOWER) && (rd_q.score >= item_q.beta)) ||
		             ((rd_q.kind == KIND_UPPER) && (rd_q.score <= item_q.alpha));
		probe_hit  = (item_q.func == FUNC_PROBE) && rd_q.valid && same_key &&
		             (rd_q.depth >= item_q.depth) && usable;

		if (!rd_q.valid) begin
			store_write = 1'b1;
		end else if (!same_key) begin
			store_write = deeper || (same_depth && (rd_q.age != age_q));
		end else begin
			store_write = deeper ||
			              ((item_q.bound_kind == KIND_EXACT) && (rd_q.kind != KIND_EXACT));
		end
		store_write = store_write && (item_q.func == FUNC_STORE);

		res_nxt = '0;
		if (probe_hit) begin
			res_nxt.hit         = 1'b1;
			res_nxt.found_score = rd_q.score;
			res_nxt.found_depth = rd_q.depth;
			res_nxt.found_kind  = rd_q.kind;
			res_nxt.found_move  = rd_q.move;
		end
		res_nxt.replaced = store_write;
	end

	// Select the single write port: clearing pass or store
	always_comb begin
		wr_en   = cmd.clr_en || (cmd.eval && store_write);
		wr_addr = cmd.clr_en ? clr_q : item_idx;
		wr_word = '0;
		if (!cmd.clr_en) begin
			wr_word.valid = 1'b1;
			wr_word.key   = item_q.key;
			wr_word.score = item_q.score;
			wr_word.depth = item_q.depth;
			wr_word.kind  = item_q.bound_kind;
			wr_word.move  = item_q.move_code;
			wr_word.age   = age_q;
		end
	end

	// Table memory: read on accept, write on clear or store
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_word;
		if (cmd.accept) rd_q <= mem[item.key[INDEX_BITS-1:0]];
	end

	// Advance the search age, wrapping at 16 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (cmd.eval && (item_q.func == FUNC_NEW_ITER)) begin
			age_q <= age_q + 16'd1;
		end
	end

	// Register the result beat and its strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.eval;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) res_q <= res_nxt;
	end

	assign result = res_q;
	assign done   = done_q;

endmodule

// ===== rtl/transposition_table_probe_store_core.sv =====
// Direct-mapped search-score table with probe, store and new-iteration
// operations. After reset the block holds busy high while a clearing pass
// empties every slot. A beat is taken when start is high and busy is low;
// each beat is handled in two steps, one to read its slot from the single-port
// table memory and one to evaluate and write it back, so busy is high for the
// cycle after each accepted beat and no new beat is taken until that one is
// evaluated. The result appears on result, marked by done for exactly one
// cycle, in the cycle after evaluation; the receiver cannot stall it, so it
// must take every beat as it comes.
module transposition_table_probe_store_core #(
	parameter int INDEX_BITS = ttps_pkg::TTPS_INDEX_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ttps_pkg::item_t   item,
	output ttps_pkg::result_t result,
	output logic              done
);
	import ttps_pkg::*;

	cmd_t    cmd;
	status_t status;

	ttps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	ttps_dp #(
		.INDEX_BITS (INDEX_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.status (status),
		.result (result),
		.done   (done)
	);

	// A result beat follows exactly one evaluation cycle
	a_done_after_eval: assert property (
		@(posedge clk) disable iff (!arst_n) done |-> $past(cmd.eval)
	) else $error("result strobe without evaluation");

	// An accepted beat blocks the next one for its evaluation cycle
	a_busy_after_accept: assert property (
		@(posedge clk) disable iff (!arst_n) (start && !busy) |=> (busy && cmd.eval)
	) else $error("accepted beat not evaluated");

	// A result never reports both a hit and a write
	a_hit_or_replace: assert property (
		@(posedge clk) disable iff (!arst_n) done |-> !(result.hit && result.replaced)
	) else $error("hit and replaced in one result");

	// No beat is taken during the clearing pass
	a_no_accept_in_clear: assert property (
		@(posedge clk) disable iff (!arst_n) cmd.clr_en |-> (busy && !cmd.accept)
	) else $error("beat accepted while clearing");

endmodule

// ===== test/tb.sv =====
module tb;
	import ttps_pkg::*;

	localparam int          SLOTS          = 1 << TTPS_INDEX_BITS;
	localparam int          RANDOM_ITEMS   = 600;
	localparam int          WATCHDOG_LIMIT = 16384;
	localparam int          POOL_GROUPS    = 8;
	localparam int          POOL_WAYS      = 3;
	localparam logic [1:0]  FUNC_UNUSED    = 2'd3;
	localparam logic [1:0]  KIND_UNUSED    = 2'd3;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

	// Directed keys; A and B share a slot, W and W2 share a slot
	localparam logic [63:0] KEY_ZERO = 64'h0000_0000_0000_0000;
	localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] KEY_A    = 64'h0123_4567_89AB_C005;
	localparam logic [63:0] KEY_B    = 64'hFEDC_BA98_7654_3005;
	localparam logic [63:0] KEY_C    = 64'h5555_AAAA_0000_1777;
	localparam logic [63:0] KEY_W    = 64'h8000_0000_0000_0ABC;
	localparam logic [63:0] KEY_W2   = 64'h0000_0000_0000_1ABC;

	typedef struct {
		int      reps;
		item_t   beat;
		result_t want;
	} dir_row_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	result_t result;
	logic    done;

	// Predicted table contents
	logic               slot_used  [SLOTS];
	logic [63:0]        slot_key   [SLOTS];
	logic signed [31:0] slot_score [SLOTS];
	logic [6:0]         slot_depth [SLOTS];
	logic [1:0]         slot_kind  [SLOTS];
	logic [15:0]        slot_move  [SLOTS];
	logic [15:0]        slot_age   [SLOTS];
	logic [15:0]        search_age;

	result_t  expected_results [$];
	dir_row_t directed_rows [$];
	logic [63:0] key_pool [POOL_GROUPS*POOL_WAYS];
	int       fault_count = 0;
	int       idle_cycles = 0;

	transposition_table_probe_store_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.result (result),
		.done   (done)
	);

	always #6 clk = ~clk;

	function automatic item_t mk_item(input logic [1:0] f, input logic [63:0] k,
		input logic signed [31:0] a, input logic signed [31:0] b, input logic [6:0] d,
		input logic signed [31:0] s, input logic [1:0] bk, input logic [15:0] m);
		item_t it;
		it.func       = f;
		it.key        = k;
		it.alpha      = a;
		it.beta       = b;
		it.depth      = d;
		it.score      = s;
		it.bound_kind = bk;
		it.move_code  = m;
		return it;
	endfunction

	function automatic result_t mk_plain(input logic wrote);
		result_t r;
		r          = '0;
		r.replaced = wrote;
		return r;
	endfunction

	function automatic result_t mk_hit(input logic signed [31:0] s, input logic [6:0] d,
		input logic [1:0] k, input logic [15:0] m);
		result_t r;
		r             = '0;
		r.hit         = 1'b1;
		r.found_score = s;
		r.found_depth = d;
		r.found_kind  = k;
		r.found_move  = m;
		return r;
	endfunction

	// Apply one beat to the predicted table and return its result
	function automatic result_t table_access(input item_t it);
		result_t     r;
		int unsigned idx;
		logic        wr;
		logic        usable;
		r   = '0;
		idx = 32'(it.key[TTPS_INDEX_BITS-1:0]);
		case (it.func)
			FUNC_PROBE: begin
				if (slot_used[idx] && slot_key[idx] == it.key &&
						slot_depth[idx] >= it.depth) begin
					usable = (slot_kind[idx] == KIND_EXACT) ||
						(slot_kind[idx] == KIND_LOWER &&
							$signed(slot_score[idx]) >= $signed(it.beta)) ||
						(slot_kind[idx] == KIND_UPPER &&
							$signed(slot_score[idx]) <= $signed(it.alpha));
					if (usable)
						r = mk_hit(slot_score[idx], slot_depth[idx], slot_kind[idx],
							slot_move[idx]);
				end
			end
			FUNC_STORE: begin
				if (!slot_used[idx])
					wr = 1'b1;
				else if (slot_key[idx] != it.key)
					wr = it.depth > slot_depth[idx] ||
						(it.depth == slot_depth[idx] && slot_age[idx] != search_age);
				else
					wr = it.depth > slot_depth[idx] ||
						(it.bound_kind == KIND_EXACT && slot_kind[idx] != KIND_EXACT);
				if (wr) begin
					slot_used[idx]  = 1'b1;
					slot_key[idx]   = it.key;
					slot_score[idx] = it.score;
					slot_depth[idx] = it.depth;
					slot_kind[idx]  = it.bound_kind;
					slot_move[idx]  = it.move_code;
					slot_age[idx]   = search_age;
					r.replaced      = 1'b1;
				end
			end
			FUNC_NEW_ITER: search_age = search_age + 16'd1;
			default: ;
		endcase
		return r;
	endfunction

	// Offer one beat after a gap, hold it until taken, and queue its result
	task automatic drive_beat(input item_t it, input int gap, input bit typed,
		input result_t want);
		result_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		predicted = table_access(it);
		expected_results.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic add_row(input int reps, input item_t it, input result_t want);
		dir_row_t row;
		row.reps = reps;
		row.beat = it;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	// Check every result beat against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("tb: result beat with nothing expected: %h", result);
			end else begin
				want = expected_results.pop_front();
				if (result.hit !== want.hit || result.found_score !== want.found_score ||
						result.found_depth !== want.found_depth ||
						result.found_kind !== want.found_kind ||
						result.found_move !== want.found_move ||
						result.replaced !== want.replaced) begin
					fault_count++;
					if (fault_count <= 10)
						$display({"tb: mismatch exp hit=%b score=%h depth=%0d kind=%0d ",
							"move=%h repl=%b, got hit=%b score=%h depth=%0d kind=%0d ",
							"move=%h repl=%b"},
							want.hit, want.found_score, want.found_depth,
							want.found_kind, want.found_move, want.replaced,
							result.hit, result.found_score, result.found_depth,
							result.found_kind, result.found_move, result.replaced);
				end
			end
		end
	end

	// Abort when no beat has been taken for too long
	always @(posedge clk) begin
		if (start === 1'b1 && busy === 1'b0)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		item_t              it;
		logic [63:0]        k;
		logic [11:0]        group_idx;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic [6:0]         d;
		logic signed [31:0] s;
		logic [1:0]         f;
		logic [1:0]         bk;
		int unsigned        idx;
		int                 sel;
		int                 gap;
		bit                 no_idle;

		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		for (int i = 0; i < SLOTS; i++)
			slot_used[i] = 1'b0;
		search_age = '0;

		// Build key groups that collide on one slot each
		for (int g = 0; g < POOL_GROUPS; g++) begin
			group_idx = 12'($urandom_range(0, SLOTS - 1));
			for (int w = 0; w < POOL_WAYS; w++) begin
				k        = {$urandom, $urandom};
				k[11:0]  = group_idx;
				key_pool[g*POOL_WAYS + w] = k;
			end
		end

		// Empty table, basic hits, bounds, replacement rules, unused codes
		add_row(1, mk_item(FUNC_PROBE, KEY_ZERO, 0, 0, 0, 0, KIND_EXACT, 0), mk_plain(0));
		add_row(1, mk_item(FUNC_PROBE, KEY_ONES, S32_MAX, S32_MIN, 127, 0, KIND_EXACT, 0),
			mk_plain(0));
		add_row(1, mk_item(FUNC_STORE, KEY_ZERO, 0, 0, 0, S32_MIN, KIND_EXACT, 0),
			mk_plain(1));
		add_row(1, mk_item(FUNC_PROBE, KEY_ZERO, S32_MIN, S32_MAX, 0, 0, KIND_EXACT, 0),
			mk_hit(S32_MIN, 0, KIND_EXACT, 16'h0000));
		add_row(1, mk_item(FUNC_STORE, KEY_ONES, 0, 0, 127, S32_MAX, KIND_LOWER, 16'hFFFF),
			mk_plain(1));
		add_row(1, mk_item(FUNC_PROBE, KEY_ONES, S32_MIN, S32_MAX, 127, 0, KIND_EXACT, 0),
			mk_hit(S32_MAX, 127, KIND_LOWER, 16'hFFFF));
		add_row(1, mk_item(FUNC_STORE, KEY_W, 0, 0, 50, 7, KIND_EXACT, 16'h0ABC),
			mk_plain(1));
		add_row(1, mk_item(FUNC_STORE, KEY_A, 0, 0, 10, 100, KIND_UPPER, 16'h1234),
			mk_plain(1));
		add_row(1, mk_item(FUNC_PROBE, KEY_A, 100, S32_MAX, 10, 0, KIND_EXACT, 0),
			mk_hit(100, 10, KIND_UPPER, 16'h1234));
		add_row(1, mk_item(FUNC_PROBE, KEY_A, 99, S32_MAX, 10, 0, KIND_EXACT, 0),
			mk_plain(0));
		add_row(1, mk_item(FUNC_PROBE, KEY_A, 100, S32_MAX, 11, 0, KIND_EXACT, 0),
			mk_plain(0));
		add_row(1, mk_item(FUNC_PROBE, KEY_B, S32_MAX, S32_MIN, 0, 0, KIND_EXACT, 0),
			mk_plain(0));
		add_row(1, mk_item(FUNC_STORE, KEY_B, 0, 0, 10, -1, KIND_EXACT, 16'h5A5A),
			mk_plain(0));
		add_row(1, mk_item(FUNC_STORE, KEY_A, 0, 0, 10, 200, KIND_EXACT, 16'h4321),
			mk_plain(1));
		add_row(1, mk_item(FUNC_STORE, KEY_A, 0, 0, 10, 300, KIND_LOWER, 16'h4321),
			mk_plain(0));
		add_row(1, mk_item(FUNC_STORE, KEY_A, 0, 0, 5, 300, KIND_EXACT, 16'h4321),
			mk_plain(0));
		add_row(1, mk_item(FUNC_NEW_ITER, KEY_ZERO, 0, 0, 0, 0, KIND_EXACT, 0), mk_plain(0));
		add_row(1, mk_item(FUNC_STORE, KEY_B, 0, 0, 10, -1, KIND_EXACT, 16'h5A5A),
			mk_plain(1));
		add_row(1, mk_item(FUNC_STORE, KEY_ZERO, 0, 0, 1, 0, KIND_UNUSED, 16'hFFFF),
			mk_plain(1));
		add_row(1, mk_item(FUNC_PROBE, KEY_ZERO, S32_MAX, S32_MIN, 0, 0, KIND_EXACT, 0),
			mk_plain(0));
		add_row(1, mk_item(FUNC_UNUSED, KEY_ONES, -1, -1, 127, -1, KIND_UNUSED, 16'hFFFF),
			mk_plain(0));
		add_row(1, mk_item(FUNC_PROBE, KEY_ONES, S32_MIN, S32_MAX, 127, 0, KIND_EXACT, 0),
			mk_hit(S32_MAX, 127, KIND_LOWER, 16'hFFFF));
		add_row(1, mk_item(FUNC_STORE, KEY_C, 0, 0, 3, -5, KIND_LOWER, 16'h0777),
			mk_plain(1));
		add_row(1, mk_item(FUNC_PROBE, KEY_C, 0, -4, 2, 0, KIND_EXACT, 0), mk_plain(0));
		add_row(1, mk_item(FUNC_PROBE, KEY_C, 0, -5, 2, 0, KIND_EXACT, 0),
			mk_hit(-5, 3, KIND_LOWER, 16'h0777));
		// W was stored at an older age, so W2 at equal depth takes the slot
		add_row(1, mk_item(FUNC_STORE, KEY_W2, 0, 0, 50, 9, KIND_EXACT, 16'h1111),
			mk_plain(1));
		add_row(1, mk_item(FUNC_PROBE, KEY_W, 0, 0, 50, 0, KIND_EXACT, 0),
			mk_plain(0));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			for (int n = 0; n < directed_rows[r].reps; n++) begin
				gap = (directed_rows[r].reps > 1) ? 0 : $urandom_range(0, 19);
				drive_beat(directed_rows[r].beat, gap, 1'b1, directed_rows[r].want);
			end
		end

		// Random traffic over colliding keys, small depths and near-boundary windows
		no_idle = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				no_idle = ($urandom_range(0, 3) == 0);

			sel = $urandom_range(0, 99);
			if (sel < 45)      f = FUNC_PROBE;
			else if (sel < 85) f = FUNC_STORE;
			else if (sel < 95) f = FUNC_NEW_ITER;
			else               f = FUNC_UNUSED;

			if ($urandom_range(0, 99) < 85)
				k = key_pool[$urandom_range(0, POOL_GROUPS*POOL_WAYS - 1)];
			else
				k = {$urandom, $urandom};
			idx = 32'(k[TTPS_INDEX_BITS-1:0]);

			sel = $urandom_range(0, 99);
			if (sel < 70)      d = 7'($urandom_range(0, 7));
			else if (sel < 85) d = 7'($urandom_range(0, 127));
			else               d = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'd127;

			bk = ($urandom_range(0, 9) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));

			sel = $urandom_range(0, 99);
			if (sel < 5)       s = S32_MIN;
			else if (sel < 10) s = S32_MAX;
			else if (sel < 15) s = 0;
			else if (sel < 20) s = -1;
			else               s = $urandom;

			// Put the window edges on or next to the stored score most of the time
			if (slot_used[idx] && $urandom_range(0, 99) < 60) begin
				a = slot_score[idx] + $signed(32'($urandom_range(0, 2))) - 1;
				b = slot_score[idx] + $signed(32'($urandom_range(0, 2))) - 1;
			end else begin
				a = $urandom;
				b = $urandom;
			end

			it  = mk_item(f, k, a, b, d, s, bk, 16'($urandom));
			gap = no_idle ? 0 : $urandom_range(0, 19);
			drive_beat(it, gap, 1'b0, '0);
		end
		start <= 1'b0;

		// Drain outstanding results, then allow the pipeline to settle
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (fault_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ttps_pkg.sv
rtl/ttps_ctrl.sv
rtl/ttps_dp.sv
rtl/transposition_table_probe_store_core.sv
test/tb.sv
